>>> design/radv_pkg.sv
package radv_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAME_W        = 13;
	localparam int STRENGTH_W     = 17;
	localparam int REACH_W        = 48;
	localparam int REACH_SPLIT    = 24;
	localparam int RATIO_SHIFT    = 32;
	localparam int CFG_DATA_W     = 48;
	localparam int CFG_IDX_W      = 2;
	localparam int LATENCY        = 7;

	localparam logic [16:0] ONE_Q16     = 17'h10000;
	localparam logic [15:0] HALF_Q16    = 16'h8000;
	localparam logic [31:0] ROUND_RATIO = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_STRENGTH      = 2'd2,
		CFG_INVERSE_REACH = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [FRAME_W-1:0]    frame_width;
		logic [FRAME_W-1:0]    frame_height;
		logic [STRENGTH_W-1:0] strength;
		logic [REACH_W-1:0]    inverse_reach;
		logic                  empty;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// width of an offset magnitude from the centre
	function automatic int mag_width(input int coord_bits);
		mag_width = (coord_bits + 1 > FRAME_W) ? coord_bits + 1 : FRAME_W;
	endfunction

	// width of the squared distance sum
	function automatic int dist_width(input int coord_bits);
		dist_width = 2 * mag_width(coord_bits) + 1;
	endfunction

endpackage

>>> design/radv_cfg.sv
module radv_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [radv_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [radv_pkg::CFG_DATA_W-1:0]      wr_data,
	output radv_pkg::cfg_t                       cfg
);

	logic [radv_pkg::FRAME_W-1:0]    width_q;
	logic [radv_pkg::FRAME_W-1:0]    height_q;
	logic [radv_pkg::STRENGTH_W-1:0] strength_q;
	logic [radv_pkg::REACH_W-1:0]    reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= radv_pkg::FRAME_W'(1);
			height_q   <= radv_pkg::FRAME_W'(1);
			strength_q <= '0;
			reach_q    <= '0;
		end else if (wr_en) begin
			case (radv_pkg::cfg_idx_t'(wr_index))
				radv_pkg::CFG_FRAME_WIDTH: begin
					width_q <= wr_data[radv_pkg::FRAME_W-1:0];
				end
				radv_pkg::CFG_FRAME_HEIGHT: begin
					height_q <= wr_data[radv_pkg::FRAME_W-1:0];
				end
				radv_pkg::CFG_STRENGTH: begin
					strength_q <= wr_data[radv_pkg::STRENGTH_W-1:0];
				end
				radv_pkg::CFG_INVERSE_REACH: begin
					reach_q <= wr_data[radv_pkg::REACH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.frame_width   = width_q;
		cfg.frame_height  = height_q;
		cfg.strength      = (strength_q > radv_pkg::ONE_Q16) ? radv_pkg::ONE_Q16 : strength_q;
		cfg.inverse_reach = reach_q;
		cfg.empty         = (width_q == '0) || (height_q == '0);
	end

endmodule

>>> design/radv_dist.sv
module radv_dist #(
	parameter int COORD_BITS = radv_pkg::COORD_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            take,
	input  logic [COORD_BITS-1:0]                           pixel_x,
	input  logic [COORD_BITS-1:0]                           pixel_y,
	input  radv_pkg::pixel_t                                pix_in,
	input  radv_pkg::cfg_t                                  cfg,
	output logic                                            valid_s3,
	output logic [radv_pkg::dist_width(COORD_BITS)-1:0]     d_s3,
	output radv_pkg::pixel_t                                pix_s3
);

	localparam int MAG_W = radv_pkg::mag_width(COORD_BITS);
	localparam int OFF_W = MAG_W + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int D_W   = radv_pkg::dist_width(COORD_BITS);

	logic [OFF_W-1:0] off_x, off_y, neg_x, neg_y;
	logic [MAG_W-1:0] mag_x, mag_y;

	logic             valid_s1, valid_s2;
	logic [MAG_W-1:0] mag_x_s1, mag_y_s1;
	logic [SQ_W-1:0]  sq_x_s2, sq_y_s2;
	radv_pkg::pixel_t pix_s1, pix_s2;

	// doubled coordinates: 2p + 1 - size
	assign off_x = OFF_W'({pixel_x, 1'b1}) - OFF_W'(cfg.frame_width);
	assign off_y = OFF_W'({pixel_y, 1'b1}) - OFF_W'(cfg.frame_height);
	assign neg_x = OFF_W'(0) - off_x;
	assign neg_y = OFF_W'(0) - off_y;
	assign mag_x = off_x[OFF_W-1] ? neg_x[MAG_W-1:0] : off_x[MAG_W-1:0];
	assign mag_y = off_y[OFF_W-1] ? neg_y[MAG_W-1:0] : off_y[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take && !cfg.empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_x_s1 <= mag_x;
		mag_y_s1 <= mag_y;
		pix_s1   <= pix_in;
		sq_x_s2  <= SQ_W'(mag_x_s1) * SQ_W'(mag_x_s1);
		sq_y_s2  <= SQ_W'(mag_y_s1) * SQ_W'(mag_y_s1);
		pix_s2   <= pix_s1;
		d_s3     <= D_W'(sq_x_s2) + D_W'(sq_y_s2);
		pix_s3   <= pix_s2;
	end

endmodule

>>> design/radv_ratio.sv
module radv_ratio #(
	parameter int COORD_BITS = radv_pkg::COORD_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            valid_s3,
	input  logic [radv_pkg::dist_width(COORD_BITS)-1:0]     d_s3,
	input  radv_pkg::pixel_t                                pix_s3,
	input  radv_pkg::cfg_t                                  cfg,
	output logic                                            valid_s6,
	output logic [16:0]                                     factor_s6,
	output radv_pkg::pixel_t                                pix_s6
);

	localparam int D_W    = radv_pkg::dist_width(COORD_BITS);
	localparam int HI_W   = radv_pkg::REACH_W - radv_pkg::REACH_SPLIT;
	localparam int P_W    = D_W + ((HI_W > radv_pkg::REACH_SPLIT) ? HI_W : radv_pkg::REACH_SPLIT);
	localparam int A_W    = D_W + radv_pkg::REACH_W + 1;
	localparam int RQ_W   = A_W - radv_pkg::RATIO_SHIFT;
	localparam int DARK_W = 2 * radv_pkg::STRENGTH_W;

	logic [radv_pkg::REACH_SPLIT-1:0] reach_lo;
	logic [HI_W-1:0]                  reach_hi;
	logic [A_W-1:0]                   acc;
	logic [RQ_W-1:0]                  rq;
	logic [DARK_W-1:0]                dark_full;
	logic [16:0]                      dark;

	logic             valid_s4, valid_s5;
	logic [P_W-1:0]   prod_lo_s4, prod_hi_s4;
	logic [16:0]      ratio_s5;
	radv_pkg::pixel_t pix_s4, pix_s5;

	assign reach_lo = cfg.inverse_reach[radv_pkg::REACH_SPLIT-1:0];
	assign reach_hi = cfg.inverse_reach[radv_pkg::REACH_W-1:radv_pkg::REACH_SPLIT];

	// ratio = round(d * reach / 2^32), saturated at one
	assign acc = (A_W'(prod_hi_s4) << radv_pkg::REACH_SPLIT) + A_W'(prod_lo_s4)
		+ A_W'(radv_pkg::ROUND_RATIO);
	assign rq  = acc[A_W-1:radv_pkg::RATIO_SHIFT];

	assign dark_full = DARK_W'(cfg.strength) * DARK_W'(ratio_s5) + DARK_W'(radv_pkg::HALF_Q16);
	assign dark      = dark_full[32:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		prod_lo_s4 <= P_W'(d_s3) * P_W'(reach_lo);
		prod_hi_s4 <= P_W'(d_s3) * P_W'(reach_hi);
		pix_s4     <= pix_s3;
		ratio_s5   <= (rq > RQ_W'(radv_pkg::ONE_Q16)) ? radv_pkg::ONE_Q16 : rq[16:0];
		pix_s5     <= pix_s4;
		factor_s6  <= radv_pkg::ONE_Q16 - dark;
		pix_s6     <= pix_s5;
	end

endmodule

>>> design/radv_scale.sv
module radv_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s6,
	input  logic [16:0]      factor_s6,
	input  radv_pkg::pixel_t pix_s6,
	output logic             valid_s7,
	output radv_pkg::pixel_t pix_s7
);

	logic [24:0] red_full, green_full, blue_full;

	// round(c * factor / 2^16); never exceeds 255 as factor <= one
	assign red_full   = 25'(pix_s6.red)   * 25'(factor_s6) + 25'(radv_pkg::HALF_Q16);
	assign green_full = 25'(pix_s6.green) * 25'(factor_s6) + 25'(radv_pkg::HALF_Q16);
	assign blue_full  = 25'(pix_s6.blue)  * 25'(factor_s6) + 25'(radv_pkg::HALF_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		pix_s7.red   <= red_full[23:16];
		pix_s7.green <= green_full[23:16];
		pix_s7.blue  <= blue_full[23:16];
		pix_s7.alpha <= pix_s6.alpha;
	end

endmodule

>>> design/radial_vignette_pixel.sv
// channel   direction  transfer when           payload
// input     in         start && !busy         pixel_x, pixel_y, in_red/green/blue/alpha
// result    out        done (one cycle)       out_red/green/blue/alpha
// config    in         wr_en                  wr_index, wr_data
//
// Seven-stage pipeline, one pixel per clock; each result is registered in stage s7.
// The 48-bit reach multiply is split into two partial products plus an add.
// busy never rises; an empty frame drops the pixel at entry and gives no result.
// arst_n clears the valid chain and loads the register reset values.
// No stalls: done is a one-cycle strobe and the receiver must take it.
module radial_vignette_pixel #(
	parameter int COORD_BITS = radv_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [COORD_BITS-1:0]                pixel_x,
	input  logic [COORD_BITS-1:0]                pixel_y,
	input  logic [7:0]                           in_red,
	input  logic [7:0]                           in_green,
	input  logic [7:0]                           in_blue,
	input  logic [7:0]                           in_alpha,
	output logic                                 done,
	output logic [7:0]                           out_red,
	output logic [7:0]                           out_green,
	output logic [7:0]                           out_blue,
	output logic [7:0]                           out_alpha,
	input  logic                                 wr_en,
	input  logic [radv_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [radv_pkg::CFG_DATA_W-1:0]      wr_data
);

	localparam int D_W = radv_pkg::dist_width(COORD_BITS);

	radv_pkg::cfg_t   cfg;
	radv_pkg::pixel_t pix_in, pix_s3, pix_s6, pix_s7;
	logic             take;
	logic             valid_s3, valid_s6;
	logic [D_W-1:0]   d_s3;
	logic [16:0]      factor_s6;

	assign busy = 1'b0;
	assign take = start && !busy;

	assign pix_in.red   = in_red;
	assign pix_in.green = in_green;
	assign pix_in.blue  = in_blue;
	assign pix_in.alpha = in_alpha;

	radv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	radv_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.pix_in   (pix_in),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.d_s3     (d_s3),
		.pix_s3   (pix_s3)
	);

	radv_ratio #(
		.COORD_BITS (COORD_BITS)
	) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.d_s3      (d_s3),
		.pix_s3    (pix_s3),
		.cfg       (cfg),
		.valid_s6  (valid_s6),
		.factor_s6 (factor_s6),
		.pix_s6    (pix_s6)
	);

	radv_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s6  (valid_s6),
		.factor_s6 (factor_s6),
		.pix_s6    (pix_s6),
		.valid_s7  (done),
		.pix_s7    (pix_s7)
	);

	assign out_red   = pix_s7.red;
	assign out_green = pix_s7.green;
	assign out_blue  = pix_s7.blue;
	assign out_alpha = pix_s7.alpha;

	// every result traces back to an earlier matching input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, radv_pkg::LATENCY))
	else $error("result without matching input transfer");

	// alpha rides the pipeline untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_alpha == $past(in_alpha, radv_pkg::LATENCY)))
	else $error("alpha misaligned with result");

	// empty frame gives no result
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && cfg.empty) |-> ##7 !done)
	else $error("result for empty frame");

	// darkening never takes the factor below zero
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (factor_s6 <= radv_pkg::ONE_Q16))
	else $error("factor out of range");

endmodule
